/* rtl/core/amp_fault_retry_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// amp_fault_retry_sequencer_defines
// assertion macros used by the checker file afrs_checker
// ----------------------------------------------------------------------------
`ifndef AMP_FAULT_RETRY_SEQUENCER_DEFINES_SVH
`define AMP_FAULT_RETRY_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AFRS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afrs check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define AFRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afrs check failed");

`endif

/* rtl/core/afrs_pkg.sv */
// ----------------------------------------------------------------------------
// afrs_pkg
// types and constants of the amplifier fault retry sequencer
// ----------------------------------------------------------------------------
package afrs_pkg;

    localparam int TimeW     = 16;
    localparam int CfgIndexW = 2;
    localparam int InDataW   = 8;
    localparam int OutDataW  = 8;

    localparam logic [TimeW-1:0] DefaultTimeMs = TimeW'(2);
    localparam logic [TimeW-1:0] TimeMax       = {TimeW{1'b1}};

    typedef enum logic [1:0] {
        PH_OK     = 2'd0,
        PH_ERR    = 2'd1,
        PH_PULSE  = 2'd2,
        PH_SETTLE = 2'd3
    } phase_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_REENABLE = 2'd0,
        REG_PULSE    = 2'd1,
        REG_SETTLE   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [TimeW-1:0] reenable_ms;
        logic [TimeW-1:0] pulse_ms;
        logic [TimeW-1:0] settle_ms;
    } cfg_t;

    // lowest bit last: fault_n sits at bit 0
    typedef struct packed {
        logic clear_warn;
        logic clear_err;
        logic ms_tick;
        logic clip_otw_n;
        logic fault_n;
    } in_item_t;

    // lowest bit last: reset_n sits at bit 0
    typedef struct packed {
        logic   warn_seen;
        logic   fault_seen;
        logic   warn_now;
        logic   fault_now;
        phase_t phase;
        logic   reset_n;
    } result_t;

endpackage

/* rtl/core/afrs_cfg.sv */
// ----------------------------------------------------------------------------
// afrs_cfg
// configuration register file, one write beat per cycle
// ----------------------------------------------------------------------------
module afrs_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [afrs_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [afrs_pkg::TimeW-1:0]     cfg_data,
    output afrs_pkg::cfg_t                cfg
);
    import afrs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_REENABLE: cfg_next.reenable_ms = cfg_data;
                REG_PULSE:    cfg_next.pulse_ms    = cfg_data;
                REG_SETTLE:   cfg_next.settle_ms   = cfg_data;
                default:      cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reenable_ms <= '0;
            cfg_reg.pulse_ms    <= DefaultTimeMs;
            cfg_reg.settle_ms   <= DefaultTimeMs;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/afrs_core.sv */
// ----------------------------------------------------------------------------
// afrs_core
// sequencer state and its one-step update logic
// ----------------------------------------------------------------------------
module afrs_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  afrs_pkg::in_item_t item,
    input  afrs_pkg::cfg_t     cfg,
    output afrs_pkg::result_t  result
);
    import afrs_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [TimeW-1:0] elapsed_reg;
    logic [TimeW-1:0] elapsed_next;
    logic             level_reg;
    logic             level_next;
    logic             fault_seen_reg;
    logic             fault_seen_next;
    logic             warn_seen_reg;
    logic             warn_seen_next;

    logic             fault;
    logic             warn;
    logic [TimeW-1:0] elapsed_cnt;

    assign fault = ~item.fault_n;
    assign warn  = ~item.clip_otw_n;

    // saturating millisecond count for this step
    assign elapsed_cnt = (item.ms_tick && (elapsed_reg != TimeMax))
                       ? elapsed_reg + TimeW'(1) : elapsed_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        level_next      = level_reg;
        fault_seen_next = item.clear_err  ? 1'b0 : fault_seen_reg;
        warn_seen_next  = item.clear_warn ? 1'b0 : warn_seen_reg;

        if (cfg.reenable_ms != '0)
        begin
            elapsed_next = elapsed_cnt;
            case (phase_reg)
                PH_OK:
                begin
                    if (fault)
                    begin
                        phase_next   = PH_ERR;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        level_next = 1'b1;
                    end
                end
                PH_ERR:
                begin
                    if (elapsed_cnt >= cfg.reenable_ms)
                    begin
                        phase_next   = PH_PULSE;
                        elapsed_next = '0;
                    end
                end
                PH_PULSE:
                begin
                    if (elapsed_cnt >= cfg.pulse_ms)
                    begin
                        phase_next   = PH_SETTLE;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        level_next = 1'b0;
                    end
                end
                PH_SETTLE:
                begin
                    if (elapsed_cnt >= cfg.settle_ms)
                    begin
                        phase_next   = PH_OK;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        level_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_OK;
                end
            endcase
            fault_seen_next = fault_seen_next | fault;
            warn_seen_next  = warn_seen_next  | warn;
        end
        else
        begin
            level_next = 1'b1;
        end
    end

    assign result.reset_n    = level_next;
    assign result.phase      = phase_next;
    assign result.fault_now  = fault;
    assign result.warn_now   = warn;
    assign result.fault_seen = fault_seen_next;
    assign result.warn_seen  = warn_seen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OK;
            elapsed_reg    <= '0;
            level_reg      <= 1'b1;
            fault_seen_reg <= 1'b0;
            warn_seen_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            level_reg      <= level_next;
            fault_seen_reg <= fault_seen_next;
            warn_seen_reg  <= warn_seen_next;
        end
    end

endmodule

/* rtl/core/amp_fault_retry_sequencer.sv */
// ----------------------------------------------------------------------------
// amp_fault_retry_sequencer
// fault recovery sequencer for an audio amplifier reset pin
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  s_axis    in    s_tvalid/s_tready  s_tdata: one pin evaluation per beat
//  m_axis    out   m_tvalid/m_tready  m_tdata: one result per input beat
//  cfg       in    cfg_valid/cfg_ready cfg_index, cfg_data: register write
//
//  an accepted beat passes through the input register, then the state update
//  that loads the result register, before it shows on m_tdata
//  one beat per cycle is sustained while m_tready stays high; the limit is the
//  single state update per cycle in afrs_core
//  rst_n is asynchronous and active low; it empties both registers and
//  restores the state and config reset values
//  a stalled m_tready holds the result; one more beat is still taken into the
//  input register before s_tready drops
//
module amp_fault_retry_sequencer
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fault_n, clip_otw_n, ms_tick, clear_err, clear_warn, upper bits unused
    input  logic [afrs_pkg::InDataW-1:0]   s_tdata,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // reset_n, phase[1:0], fault_now, warn_now, fault_seen, warn_seen, zero fill
    output logic [afrs_pkg::OutDataW-1:0]  m_tdata,
    // config writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [afrs_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [afrs_pkg::TimeW-1:0]     cfg_data
);
    import afrs_pkg::*;

    localparam int ItemW = $bits(in_item_t);
    localparam int ResW  = $bits(result_t);

    cfg_t     cfg;
    result_t  step_result;

    // input register
    logic     in_valid_reg;
    in_item_t in_item_reg;

    // result register
    logic     res_valid_reg;
    result_t  res_reg;

    // the input item moves on when the result register is empty or drains
    logic     res_load;
    logic     in_take;

    assign res_load = in_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || res_load;
    assign in_take  = s_tvalid && s_tready;

    afrs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state commits only when the result is loaded
    afrs_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (res_load),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (res_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item_t'(s_tdata[ItemW-1:0]);
        end
        if (res_load)
        begin
            res_reg <= step_result;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {{(OutDataW-ResW){1'b0}}, res_reg};

endmodule

/* rtl/core/afrs_checker.sv */
// ----------------------------------------------------------------------------
// afrs_checker
// port-level checks of the sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "amp_fault_retry_sequencer_defines.svh"

module afrs_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [afrs_pkg::OutDataW-1:0]  m_tdata,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);
    import afrs_pkg::*;

    // beats taken in but not yet delivered
    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_beat;
    logic       out_beat;
    logic       cfg_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;
    assign cfg_beat = cfg_valid && cfg_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_beat && !out_beat)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a stalled result holds
    `AFRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // no result without an input beat behind it
    `AFRS_ASSERT_IMPL(a_out_backed, m_tvalid, pend_reg != 2'd0)
    // at most two beats in flight, and a full pipe takes input only while a result leaves
    `AFRS_ASSERT_IMPL(a_pend_bound, pend_reg == 2'd2, !s_tready || out_beat)
    // the fill bit of the result stays zero, config stays writable
    `AFRS_ASSERT_IMPL(a_fill_zero, m_tvalid || cfg_beat, !m_tdata[7] && cfg_ready)

endmodule

bind amp_fault_retry_sequencer afrs_checker u_afrs_checker (.*);
